// File: hdl/mpg_pkg.sv
`timescale 1ns / 1ps
// Package for the Morse potential and gradient evaluator.
// Holds payload structs, register codes, fixed-point constants and the
// split-multiplier helpers. No dependencies.
package mpg_pkg;

  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned WORD_BITS = 32;

  // Register reset values, unsigned Q7.24
  localparam logic [30:0] WELL_DEPTH_RST = 31'd3103785;
  localparam logic [30:0] WIDTH_INV_RST  = 31'd20303787;
  localparam logic [30:0] EQ_DIST_RST    = 31'd29861767;

  // log2(e) and ln(2) in Q.62
  localparam logic [63:0] LOG2E_Q62 = 64'h5C551D94AE0BF85E;
  localparam logic [63:0] LN2_Q62   = 64'd3196577161300663915;

  typedef enum logic [1:0] {
    CFG_WELL_DEPTH = 2'd0,
    CFG_WIDTH_INV  = 2'd1,
    CFG_EQ_DIST    = 2'd2
  } cfg_idx_e;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SAT  = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] pos_x;
    logic signed [WORD_BITS-1:0] pos_y;
    logic signed [WORD_BITS-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic        [30:0]          energy;
    logic signed [WORD_BITS-1:0] grad_x;
    logic signed [WORD_BITS-1:0] grad_y;
    logic signed [WORD_BITS-1:0] grad_z;
    logic        [1:0]           status;
  } out_item_t;

  // Four partial products (64 and 68 bits wide) of a 64 x 68 product
  typedef struct packed {
    logic [63:0] ll;
    logic [67:0] lh;
    logic [63:0] hl;
    logic [67:0] hh;
  } pp_t;

  typedef struct packed {
    logic [63:0] val;
    logic        sat;
  } clamp_t;

  function automatic pp_t pp_mul(input logic [63:0] a, input logic [67:0] b);
    pp_t p;
    p.ll = 64'(a[31:0]) * 64'(b[31:0]);
    p.lh = 68'(a[31:0]) * 68'(b[67:32]);
    p.hl = 64'(a[63:32]) * 64'(b[31:0]);
    p.hh = 68'(a[63:32]) * 68'(b[67:32]);
    return p;
  endfunction

  function automatic logic [131:0] pp_sum(input pp_t p);
    return 132'(p.ll) + (132'(p.lh) << 32) + (132'(p.hl) << 32) + (132'(p.hh) << 64);
  endfunction

  // Round half up, shift right by sh (1..63), clamp to lim
  function automatic clamp_t rnd_clamp(input logic [131:0] p, input int unsigned sh,
                                       input logic [63:0] lim);
    logic [131:0] rs;
    clamp_t       c;
    rs = (p + (132'd1 << (sh - 1))) >> sh;
    if (rs > 132'(lim)) begin
      c.val = lim;
      c.sat = 1'b1;
    end else begin
      c.val = rs[63:0];
      c.sat = 1'b0;
    end
    return c;
  endfunction

endpackage

// File: hdl/morse_potential_and_gradient.sv
`timescale 1ns / 1ps
// Morse potential and gradient evaluator, one fully pipelined datapath.
// Depends on mpg_pkg (payload structs, constants, multiply helpers).

// Takes one position per cycle and returns energy, gradient and status at a
// sustained rate of one item per cycle while the output is ready.
// The pipeline depth is set by the bit-per-stage square root (32 stages), the three
// parallel bit-per-stage dividers for the unit vector (33 stages) and the
// 24-term exponential series (4 stages per term, two per split 64-bit multiply).
// Stalls propagate backward only as far as the first empty stage, so the
// input keeps taking items into bubbles while a result waits at the output.
// Configuration writes take effect at once and must be made with the
// pipeline empty.
module morse_potential_and_gradient (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mpg_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mpg_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import mpg_pkg::*;

  // Stage map
  localparam int unsigned S_SQ    = 1;
  localparam int unsigned S_SQRT0 = 2;
  localparam int unsigned S_ROOT  = 34;
  localparam int unsigned S_DIV0  = 35;
  localparam int unsigned S_UPROD = 68;
  localparam int unsigned S_U     = 69;
  localparam int unsigned S_YPP   = 70;
  localparam int unsigned S_Y     = 71;
  localparam int unsigned S_FR    = 72;
  localparam int unsigned S_GPP   = 73;
  localparam int unsigned S_G     = 74;
  localparam int unsigned S_TAY0  = 75;
  localparam int unsigned N_TERMS = 24;
  localparam int unsigned S_SUM   = S_TAY0 + 4 * N_TERMS;
  localparam int unsigned S_ESH   = S_SUM + 1;
  localparam int unsigned S_E     = S_SUM + 2;
  localparam int unsigned S_QM    = S_SUM + 3;
  localparam int unsigned S_PP1   = S_SUM + 4;
  localparam int unsigned S_Q2    = S_SUM + 5;
  localparam int unsigned S_PP2   = S_SUM + 6;
  localparam int unsigned S_EN    = S_SUM + 7;
  localparam int unsigned S_PP3   = S_SUM + 8;
  localparam int unsigned S_A     = S_SUM + 9;
  localparam int unsigned S_PP4   = S_SUM + 10;
  localparam int unsigned S_LAST  = S_SUM + 11;
  localparam int unsigned NSTG    = S_LAST + 1;

  localparam logic [62:0] E_ONE = 63'd1 << 32;
  localparam logic [62:0] E_CAP = 63'd1 << 62;
  localparam logic [63:0] POS_LIM = 64'((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam logic [63:0] NEG_LIM = 64'd1 << (WORD_BITS - 1);

  // Everything an item carries down the pipe
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [65:0]      rem;
    logic [31:0]      root;
    logic [31:0]      r;
    logic             zero;
    logic             grow;
    logic [31:0]      dmag;
    logic [2:0][33:0] drem;
    logic [2:0][32:0] quo;
    logic [62:0]      uprod;
    logic [28:0]      u;
    logic             big;
    logic             tiny;
    logic [61:0]      y;
    logic [6:0]       n;
    logic [61:0]      fs;
    logic [61:0]      g;
    logic [62:0]      term;
    logic [61:0]      mq;
    logic [63:0]      msum;
    logic [6:0]       sh;
    logic             ncap;
    logic [63:0]      er;
    logic [62:0]      e;
    logic             sat;
    logic             qneg;
    logic [61:0]      qmag;
    logic [63:0]      q2;
    logic [37:0]      p1;
    logic [63:0]      t;
    logic [63:0]      a;
    logic [30:0]      energy;
    logic [2:0][31:0] grad;
    logic [1:0]       status;
    pp_t [2:0]        pp;
  } pipe_t;

  logic [30:0] well_depth_q, width_inv_q, eq_dist_q;

  pipe_t            st_q [NSTG];
  pipe_t            st_d [NSTG];
  logic [NSTG-1:0]  vld_q;
  logic [NSTG-1:0]  vld_in;
  logic [NSTG-1:0]  adv;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      well_depth_q <= WELL_DEPTH_RST;
      width_inv_q  <= WIDTH_INV_RST;
      eq_dist_q    <= EQ_DIST_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WELL_DEPTH: well_depth_q <= cfg_data_i[30:0];
        CFG_WIDTH_INV:  width_inv_q  <= cfg_data_i[30:0];
        CFG_EQ_DIST:    eq_dist_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Flow control: a stage advances if the output is ready or it or any stage after it is empty
  genvar gi;
  generate
    for (gi = 0; gi < NSTG; gi++) begin : g_adv
      assign adv[gi] = out_ready_i | ~(&vld_q[NSTG-1:gi]);
    end
  endgenerate

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NSTG-1];

  // Valid bits shift in step with the data
  assign vld_in = {vld_q[NSTG-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (adv[i]) begin
          vld_q[i] <= vld_in[i];
        end
      end
    end
  end

  // Stage registers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NSTG; i++) begin
      if (adv[i]) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  // Magnitudes and signs of the coordinates
  always_comb begin
    logic [2:0][31:0] v;
    st_d[0] = '0;
    v[0] = in_data_i.pos_x;
    v[1] = in_data_i.pos_y;
    v[2] = in_data_i.pos_z;
    for (int j = 0; j < 3; j++) begin
      st_d[0].neg[j] = v[j][31];
      st_d[0].mag[j] = v[j][31] ? (~v[j] + 32'd1) : v[j];
    end
  end

  // Squared norm, exact
  always_comb begin
    st_d[S_SQ] = st_q[S_SQ-1];
    st_d[S_SQ].rem = 66'(64'(st_q[S_SQ-1].mag[0]) * 64'(st_q[S_SQ-1].mag[0]))
                   + 66'(64'(st_q[S_SQ-1].mag[1]) * 64'(st_q[S_SQ-1].mag[1]))
                   + 66'(64'(st_q[S_SQ-1].mag[2]) * 64'(st_q[S_SQ-1].mag[2]));
    st_d[S_SQ].root = '0;
  end

  // Square root, one result bit per stage, MSB first
  generate
    for (gi = 0; gi < 32; gi++) begin : g_sqrt
      localparam int unsigned Bit = 31 - gi;
      always_comb begin
        logic [65:0] trial;
        st_d[S_SQRT0+gi] = st_q[S_SQRT0+gi-1];
        trial = (66'(st_q[S_SQRT0+gi-1].root) << (Bit + 1)) | (66'd1 << (2 * Bit));
        if (st_q[S_SQRT0+gi-1].rem >= trial) begin
          st_d[S_SQRT0+gi].rem       = st_q[S_SQRT0+gi-1].rem - trial;
          st_d[S_SQRT0+gi].root[Bit] = 1'b1;
        end
      end
    end
  endgenerate

  // Radius, distance to the well minimum, divider setup
  always_comb begin
    pipe_t s;
    s = st_q[S_ROOT-1];
    s.r    = s.root;
    s.zero = (s.root == '0);
    s.grow = s.root < 32'(eq_dist_q);
    s.dmag = s.grow ? (32'(eq_dist_q) - s.root) : (s.root - 32'(eq_dist_q));
    for (int j = 0; j < 3; j++) begin
      s.drem[j] = 34'(s.mag[j]);
      s.quo[j]  = '0;
    end
    st_d[S_ROOT] = s;
  end

  // Unit-vector ratios mag * 2^32 / r, one quotient bit per stage
  generate
    for (gi = 0; gi < 33; gi++) begin : g_div
      always_comb begin
        pipe_t       s;
        logic [33:0] d;
        s = st_q[S_DIV0+gi-1];
        for (int j = 0; j < 3; j++) begin
          d = (gi == 0) ? s.drem[j] : (s.drem[j] << 1);
          if (d >= 34'(s.r)) begin
            s.drem[j] = d - 34'(s.r);
            s.quo[j]  = {s.quo[j][31:0], 1'b1};
          end else begin
            s.drem[j] = d;
            s.quo[j]  = {s.quo[j][31:0], 1'b0};
          end
        end
        st_d[S_DIV0+gi] = s;
      end
    end
  endgenerate

  // alpha * |r - r_eq|
  always_comb begin
    st_d[S_UPROD] = st_q[S_UPROD-1];
    st_d[S_UPROD].uprod = 63'(width_inv_q) * 63'(st_q[S_UPROD-1].dmag);
  end

  // Exponent argument, early-out checks
  always_comb begin
    logic [39:0] uf;
    st_d[S_U] = st_q[S_U-1];
    uf = 40'((64'(st_q[S_U-1].uprod) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    st_d[S_U].big  = st_q[S_U-1].grow && (uf >= (40'd21 << FRAC_BITS));
    st_d[S_U].tiny = !st_q[S_U-1].grow && (uf >= (40'd32 << FRAC_BITS));
    st_d[S_U].u    = uf[28:0];
  end

  // u * log2(e)
  always_comb begin
    st_d[S_YPP] = st_q[S_YPP-1];
    st_d[S_YPP].pp[0] = pp_mul(64'(st_q[S_YPP-1].u), 68'(LOG2E_Q62));
  end

  always_comb begin
    clamp_t c;
    st_d[S_Y] = st_q[S_Y-1];
    c = rnd_clamp(pp_sum(st_q[S_Y-1].pp[0]), FRAC_BITS + 6, '1);
    st_d[S_Y].y = c.val[61:0];
  end

  // Integer and fractional part of the base-2 exponent
  always_comb begin
    logic [55:0] fr;
    logic [6:0]  n;
    st_d[S_FR] = st_q[S_FR-1];
    n  = 7'(st_q[S_FR-1].y[61:56]);
    fr = st_q[S_FR-1].y[55:0];
    if (!st_q[S_FR-1].grow && (fr != '0)) begin
      n  = n + 7'd1;
      fr = ~fr + 56'd1;
    end
    st_d[S_FR].n  = n;
    st_d[S_FR].fs = {fr, 6'b0};
  end

  // g = frac * ln2
  always_comb begin
    st_d[S_GPP] = st_q[S_GPP-1];
    st_d[S_GPP].pp[0] = pp_mul(64'(st_q[S_GPP-1].fs), 68'(LN2_Q62));
  end

  always_comb begin
    clamp_t c;
    st_d[S_G] = st_q[S_G-1];
    c = rnd_clamp(pp_sum(st_q[S_G-1].pp[0]), 62, '1);
    st_d[S_G].g    = c.val[61:0];
    st_d[S_G].term = E_CAP;
    st_d[S_G].msum = '0;
  end

  // Taylor series of exp(g): term_k = round(term * g) / k, four stages each
  generate
    for (gi = 0; gi < N_TERMS; gi++) begin : g_tay
      localparam int unsigned B = S_TAY0 + 4 * gi;
      localparam logic [67:0] RecipK = ((68'd1 << 67) + 68'(gi)) / 68'(gi + 1);
      always_comb begin
        st_d[B] = st_q[B-1];
        st_d[B].pp[0] = pp_mul(64'(st_q[B-1].term), 68'(st_q[B-1].g));
        st_d[B].msum  = st_q[B-1].msum + 64'(st_q[B-1].term);
      end
      always_comb begin
        clamp_t c;
        st_d[B+1] = st_q[B];
        c = rnd_clamp(pp_sum(st_q[B].pp[0]), 62, '1);
        st_d[B+1].mq = c.val[61:0];
      end
      // divide by k as a multiply with a rounded-up reciprocal
      always_comb begin
        st_d[B+2] = st_q[B+1];
        st_d[B+2].pp[0] = pp_mul(64'(st_q[B+1].mq), RecipK);
      end
      always_comb begin
        logic [131:0] p;
        st_d[B+3] = st_q[B+2];
        p = pp_sum(st_q[B+2].pp[0]) >> 67;
        st_d[B+3].term = p[62:0];
      end
    end
  endgenerate

  // Last term, scaling shift
  always_comb begin
    pipe_t s;
    s = st_q[S_SUM-1];
    s.msum = s.msum + 64'(s.term);
    s.ncap = s.grow && (s.n > 7'd30);
    s.sh   = s.grow ? (7'd30 - s.n) : (7'd30 + s.n);
    st_d[S_SUM] = s;
  end

  always_comb begin
    logic [64:0] rnd;
    logic [64:0] sum;
    st_d[S_ESH] = st_q[S_ESH-1];
    rnd = (st_q[S_ESH-1].sh == '0) ? '0 : (65'd1 << (st_q[S_ESH-1].sh - 7'd1));
    sum = (65'(st_q[S_ESH-1].msum) + rnd) >> st_q[S_ESH-1].sh;
    st_d[S_ESH].er = (st_q[S_ESH-1].sh >= 7'd64) ? '0 : sum[63:0];
  end

  // e in Q.32 with clamps
  always_comb begin
    pipe_t s;
    s = st_q[S_E-1];
    if (s.tiny) begin
      s.e = '0;
    end else if (s.big || s.ncap || (s.grow && (s.er > 64'(E_CAP)))) begin
      s.e   = E_CAP;
      s.sat = 1'b1;
    end else begin
      s.e = s.er[62:0];
    end
    st_d[S_E] = s;
  end

  // |1 - e|
  always_comb begin
    pipe_t       s;
    logic [62:0] d;
    s = st_q[S_QM-1];
    s.qneg = s.e > E_ONE;
    d      = s.qneg ? (s.e - E_ONE) : (E_ONE - s.e);
    s.qmag = d[61:0];
    st_d[S_QM] = s;
  end

  always_comb begin
    st_d[S_PP1] = st_q[S_PP1-1];
    st_d[S_PP1].pp[0] = pp_mul(64'(st_q[S_PP1-1].qmag), 68'(st_q[S_PP1-1].qmag));
    st_d[S_PP1].pp[1] = pp_mul(64'(well_depth_q), 68'(width_inv_q));
  end

  always_comb begin
    clamp_t c0, c1;
    st_d[S_Q2] = st_q[S_Q2-1];
    c0 = rnd_clamp(pp_sum(st_q[S_Q2-1].pp[0]), 32, '1);
    c1 = rnd_clamp(pp_sum(st_q[S_Q2-1].pp[1]), FRAC_BITS, '1);
    st_d[S_Q2].q2 = c0.val;
    st_d[S_Q2].p1 = c1.val[37:0];
  end

  always_comb begin
    st_d[S_PP2] = st_q[S_PP2-1];
    st_d[S_PP2].pp[0] = pp_mul(64'(well_depth_q), 68'(st_q[S_PP2-1].q2));
    st_d[S_PP2].pp[1] = pp_mul(64'(st_q[S_PP2-1].p1), 68'(st_q[S_PP2-1].e));
  end

  // Energy, and De*alpha*e
  always_comb begin
    clamp_t c0, c1;
    st_d[S_EN] = st_q[S_EN-1];
    c0 = rnd_clamp(pp_sum(st_q[S_EN-1].pp[0]), 32, POS_LIM);
    c1 = rnd_clamp(pp_sum(st_q[S_EN-1].pp[1]), 32, '1);
    st_d[S_EN].energy = c0.val[30:0];
    st_d[S_EN].sat    = st_q[S_EN-1].sat | c0.sat;
    st_d[S_EN].t      = c1.val;
  end

  always_comb begin
    st_d[S_PP3] = st_q[S_PP3-1];
    st_d[S_PP3].pp[0] = pp_mul(st_q[S_PP3-1].t, 68'(st_q[S_PP3-1].qmag));
  end

  always_comb begin
    clamp_t c;
    st_d[S_A] = st_q[S_A-1];
    c = rnd_clamp(pp_sum(st_q[S_A-1].pp[0]), 32, '1);
    st_d[S_A].a = c.val;
  end

  always_comb begin
    st_d[S_PP4] = st_q[S_PP4-1];
    for (int j = 0; j < 3; j++) begin
      st_d[S_PP4].pp[j] = pp_mul(st_q[S_PP4-1].a, 68'(st_q[S_PP4-1].quo[j]));
    end
  end

  // Gradient components, signs and status
  always_comb begin
    pipe_t       s;
    clamp_t      c;
    logic        gneg;
    s = st_q[S_LAST-1];
    for (int j = 0; j < 3; j++) begin
      gneg = s.qneg ^ s.neg[j];
      c    = rnd_clamp(pp_sum(s.pp[j]), 31, gneg ? NEG_LIM : POS_LIM);
      if (s.zero) begin
        s.grad[j] = '0;
      end else begin
        s.sat     = s.sat | c.sat;
        s.grad[j] = gneg ? (~c.val[31:0] + 32'd1) : c.val[31:0];
      end
    end
    if (s.zero) begin
      s.status = STATUS_ZERO;
    end else if (s.sat) begin
      s.status = STATUS_SAT;
    end else begin
      s.status = STATUS_OK;
    end
    st_d[S_LAST] = s;
  end

  // Output payload
  assign out_data_o.energy = st_q[S_LAST].energy;
  assign out_data_o.grad_x = st_q[S_LAST].grad[0];
  assign out_data_o.grad_y = st_q[S_LAST].grad[1];
  assign out_data_o.grad_z = st_q[S_LAST].grad[2];
  assign out_data_o.status = st_q[S_LAST].status;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the Morse potential and gradient evaluator.
// Needs mpg_pkg and morse_potential_and_gradient; an in-bench fixed-point
// predictor gives the expected energy, gradient and status for each position.
module testbench;
  import mpg_pkg::*;

  localparam logic [1:0]  CFG_UNUSED = 2'd3;     // no register at this index
  localparam logic [63:0] U64_MAX    = '1;
  localparam logic [63:0] E_ONE      = 64'd1 << 32;
  localparam logic [63:0] E_CLAMP    = 64'd1 << 62;
  localparam logic [63:0] FRAC56     = (64'd1 << 56) - 1;
  localparam logic [63:0] POS_LIM    = 64'h7FFF_FFFF;
  localparam logic [63:0] NEG_LIM    = 64'h8000_0000;
  localparam int          DRAIN_WAIT = 200;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // predictor copy of the registers
  logic [63:0] de_q, alpha_q, req_q;

  out_item_t expected_q[$];
  int        mismatches;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_left;
  bit        hold_req;

  morse_potential_and_gradient u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- fixed-point predictor ----------------

  // full product, rounded half up, shifted, clamped to lim
  function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                            input int sh, input logic [63:0] lim,
                                            inout bit sat);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b} + (128'd1 << (sh - 1))) >> sh;
    if (p > {64'd0, lim}) begin
      sat = 1'b1;
      return lim;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] round_down_shift(input logic [63:0] v, input int sh);
    if (sh == 0) return v;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // exp(+u) or exp(-u), u in Q8.24, result Q.32
  function automatic logic [63:0] exp_fixed(input logic [63:0] u, input bit grow,
                                            inout bit sat);
    bit          scratch;
    logic [63:0] y, n, fr, g, term, sum, e;
    scratch = 1'b0;
    if (grow && u >= (64'd21 << FRAC_BITS)) begin
      sat = 1'b1;
      return E_CLAMP;
    end
    if (!grow && u >= (64'd32 << FRAC_BITS)) return 64'd0;
    y  = mul_round(u, LOG2E_Q62, FRAC_BITS + 6, U64_MAX, scratch);
    n  = y >> 56;
    fr = y & FRAC56;
    if (!grow && fr != 0) begin
      n  = n + 1;
      fr = (64'd1 << 56) - fr;
    end
    g    = mul_round(fr << 6, LN2_Q62, 62, U64_MAX, scratch);
    term = 64'd1 << 62;
    sum  = term;
    for (int k = 1; k <= 24; k++) begin
      term = mul_round(term, g, 62, U64_MAX, scratch) / k;
      sum  = sum + term;
    end
    if (grow) begin
      if (n > 30) begin
        sat = 1'b1;
        return E_CLAMP;
      end
      e = round_down_shift(sum, 30 - int'(n));
      if (e > E_CLAMP) begin
        sat = 1'b1;
        return E_CLAMP;
      end
      return e;
    end
    if (30 + n >= 64) return 64'd0;
    return round_down_shift(sum, 30 + int'(n));
  endfunction

  function automatic out_item_t morse_predict(input in_item_t p);
    logic [31:0] coord[3];
    logic [63:0] mag[3];
    bit          neg[3];
    logic [63:0] sq, r, dmag, u, e, qmag, q2, p1, t, a, c, g, en;
    bit          grow, qneg, sat, scratch, gneg;
    out_item_t   res;
    coord[0] = p.pos_x;
    coord[1] = p.pos_y;
    coord[2] = p.pos_z;
    sat      = 1'b0;
    scratch  = 1'b0;
    sq       = 0;
    for (int j = 0; j < 3; j++) begin
      neg[j] = coord[j][31];
      mag[j] = neg[j] ? {32'd0, -coord[j]} : {32'd0, coord[j]};
      if (neg[j] && coord[j] == 32'h8000_0000) mag[j] = 64'h8000_0000;
      sq = sq + mag[j] * mag[j];
    end
    r    = int_sqrt(sq);
    grow = r < req_q;
    dmag = grow ? (req_q - r) : (r - req_q);
    u    = mul_round(alpha_q, dmag, FRAC_BITS, U64_MAX, scratch);
    e    = exp_fixed(u, grow, sat);
    qneg = e > E_ONE;
    qmag = qneg ? (e - E_ONE) : (E_ONE - e);
    q2   = mul_round(qmag, qmag, 32, U64_MAX, scratch);
    en   = mul_round(de_q, q2, 32, POS_LIM, sat);
    res.energy = en[30:0];
    p1   = mul_round(de_q, alpha_q, FRAC_BITS, U64_MAX, scratch);
    t    = mul_round(p1, e, 32, U64_MAX, scratch);
    a    = mul_round(t, qmag, 32, U64_MAX, scratch);
    for (int j = 0; j < 3; j++) begin
      g = 0;
      if (r != 0) begin
        gneg = qneg != neg[j];
        c    = (mag[j] << 32) / r;
        g    = mul_round(a, c, 31, gneg ? NEG_LIM : POS_LIM, sat);
        if (gneg) g = -g;
      end
      coord[j] = g[31:0];
    end
    res.grad_x = coord[0];
    res.grad_y = coord[1];
    res.grad_z = coord[2];
    if (r == 0) res.status = STATUS_ZERO;
    else        res.status = sat ? STATUS_SAT : STATUS_OK;
    return res;
  endfunction

  // ---------------- drivers ----------------

  // one position transfer; valid stays up back to back unless the sender idles
  task automatic send_position(input in_item_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(morse_predict(p));
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every expected result, then let the pipeline settle
  task automatic wait_drained();
    drop_valid();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_WELL_DEPTH: de_q    = {33'd0, val[30:0]};
      CFG_WIDTH_INV:  alpha_q = {33'd0, val[30:0]};
      CFG_EQ_DIST:    req_q   = {33'd0, val[30:0]};
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_params(input logic [31:0] de, input logic [31:0] alpha,
                            input logic [31:0] req);
    write_reg(CFG_WELL_DEPTH, de);
    write_reg(CFG_WIDTH_INV, alpha);
    write_reg(CFG_EQ_DIST, req);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0, 1:    return $urandom();
      2:       return 32'd0;
      3:       return $urandom_range(255) - 128;
      default: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  function automatic in_item_t rand_position();
    in_item_t p;
    p.pos_x = rand_coord();
    p.pos_y = rand_coord();
    p.pos_z = rand_coord();
    return p;
  endfunction

  function automatic in_item_t mk_pos(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z);
    in_item_t p;
    p.pos_x = x;
    p.pos_y = y;
    p.pos_z = z;
    return p;
  endfunction

  // ---------------- receiver and checker ----------------

  // random ready with an optional long hold-off
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= 600;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", out_data);
      end else begin
        want = expected_q.pop_front();
        if (out_data.energy !== want.energy || out_data.grad_x !== want.grad_x ||
            out_data.grad_y !== want.grad_y || out_data.grad_z !== want.grad_z ||
            out_data.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected e=%h g=%h/%h/%h s=%0d got e=%h g=%h/%h/%h s=%0d",
                     want.energy, want.grad_x, want.grad_y, want.grad_z, want.status,
                     out_data.energy, out_data.grad_x, out_data.grad_y, out_data.grad_z,
                     out_data.status);
        end
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_directed();
    set_params(32'd3103785, 32'd20303787, 32'd29861767);
    send_position(mk_pos(0, 0, 0));                          // zero radius
    send_position(mk_pos(32'h7FFF_FFFF, 0, 0));
    send_position(mk_pos(0, 32'h8000_0000, 0));
    send_position(mk_pos(0, 0, 32'h8000_0000));
    send_position(mk_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_position(mk_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_position(mk_pos(32'd29861767, 0, 0));              // at the well minimum
    send_position(mk_pos(0, -32'sd29861767, 0));
    send_position(mk_pos(1, 0, 0));                          // tiny radius
    send_position(mk_pos(32'hFFFF_FFFF, 1, 0));
    send_position(mk_pos(32'h1000_0000, 32'hF000_0000, 0)); // far out, tiny exponential
    send_position(mk_pos(32'h0100_0000, 32'h0100_0000, 32'hFF00_0000));
    wait_drained();
    // steep well: clamped exponential and saturated outputs
    set_params(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_position(mk_pos(32'h0100_0000, 0, 0));
    send_position(mk_pos(0, 0, 0));
    send_position(mk_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_position(mk_pos(32'h4000_0000, 32'hC000_0000, 32'h2000_0000));
    wait_drained();
    // flat well: alpha zero gives e = 1, everything zero
    set_params(32'h7FFF_FFFF, 32'd0, 32'd0);
    send_position(mk_pos(32'h0123_4567, 32'h89AB_CDEF, 0));
    send_position(mk_pos(0, 0, 0));
    wait_drained();
    write_reg(CFG_UNUSED, 32'h1234_5678);                   // ignored write
    set_params(32'h0100_0000, 32'h0400_0000, 32'h0001_0000);
    send_position(mk_pos(32'h0000_8000, 0, 32'h0000_4000));
    send_position(mk_pos(32'h0800_0000, 32'h0800_0000, 32'h0800_0000));
    wait_drained();
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      send_position(rand_position());
      // stretch with no idling on either side
      if (i == count / 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == count / 2 + 60) begin
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 10;
    hold_req     <= 1'b1;
    @(posedge clk);
    hold_req     <= 1'b0;
    for (int i = 0; i < 400; i++) send_position(rand_position());
    wait_drained();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_WELL_DEPTH;
    cfg_data      = '0;
    hold_req      = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    de_q          = {33'd0, WELL_DEPTH_RST};
    alpha_q       = {33'd0, WIDTH_INV_RST};
    req_q         = {33'd0, EQ_DIST_RST};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed();
    set_params(32'd3103785, 32'd20303787, 32'd29861767);
    test_random(600, 30, 54);
    set_params($urandom(), $urandom_range(32'h0800_0000), $urandom_range(32'h0400_0000));
    test_random(600, 54, 30);
    set_params(32'd0, 32'h7FFF_FFFF, $urandom());
    test_random(100, 0, 0);
    set_params($urandom_range(32'h0100_0000), $urandom_range(32'h0300_0000),
               $urandom_range(32'h0300_0000));
    test_random(300, 0, 0);
    test_backpressure();

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: morse_potential_and_gradient.f
hdl/mpg_pkg.sv
hdl/morse_potential_and_gradient.sv
bench/testbench.sv
